FILE: rtl/core/ccf_pkg.sv
// shared types and constants for the class counted fifo with cancel
// no dependencies
`timescale 1ns / 1ps

package ccf_pkg;

	localparam int TYPE_COUNT_DEF  = 64;
	localparam int QUEUE_DEPTH_DEF = 256;

	localparam int ACT_W   = 3;
	localparam int TYPE_W  = 6;
	localparam int CRED_W  = 16;
	localparam int CNT_W   = 7;
	localparam int SUM_W   = 13;
	localparam int STAT_W  = 2;

	localparam logic [CNT_W-1:0] LIMIT_RESET = 7'd99;

	typedef enum logic [ACT_W-1:0] {
		ACT_ADD    = 3'd0,
		ACT_REMOVE = 3'd1,
		ACT_CANCEL = 3'd2,
		ACT_COUNT  = 3'd3,
		ACT_SET    = 3'd4
	} action_t;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_MISS    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_REFUSED = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CMD,
		S_ADD1,
		S_ADD2,
		S_RH1,
		S_RH2,
		S_WALK,
		S_CX,
		S_FIN
	} state_t;

	// counter write: old value goes along so the running sum can follow
	typedef struct packed {
		logic              we;
		logic [TYPE_W-1:0] addr;
		logic [CNT_W-1:0]  wdata;
		logic [CNT_W-1:0]  old;
	} cnt_wr_t;

endpackage

FILE: rtl/core/ccf_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ccf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/ccf_cnt.sv
// per type counters in a ram with valid bits, plus the running sum
// depends on ccf_pkg and ccf_ram
`timescale 1ns / 1ps

module ccf_cnt #(
	parameter int TYPE_COUNT = ccf_pkg::TYPE_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [ccf_pkg::TYPE_W-1:0]  raddr,
	input  ccf_pkg::cnt_wr_t            wr,
	output logic [ccf_pkg::CNT_W-1:0]   rd_val,
	output logic [ccf_pkg::SUM_W-1:0]   sum
);
	import ccf_pkg::*;

	localparam int TW = $clog2(TYPE_COUNT);

	logic [(2**TW)-1:0] valid_q;
	logic               rd_vld_q;
	logic [CNT_W-1:0]   rdata;
	logic [SUM_W-1:0]   sum_q;

	ccf_ram #(.WIDTH(CNT_W), .DEPTH(TYPE_COUNT)) u_ram (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr[TW-1:0]),
		.wdata (wr.wdata),
		.raddr (raddr[TW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
			sum_q    <= '0;
		end else begin
			rd_vld_q <= valid_q[raddr[TW-1:0]];
			if (wr.we) begin
				valid_q[wr.addr[TW-1:0]] <= 1'b1;
				sum_q <= sum_q - SUM_W'(wr.old) + SUM_W'(wr.wdata);
			end
		end
	end

	// never written counter reads as zero
	assign rd_val = rd_vld_q ? rdata : '0;
	assign sum    = sum_q;

endmodule

FILE: rtl/core/class_counted_fifo_with_cancel_unit.sv
// top level: linked list queue in rams, sequencer, counters and result register
// depends on ccf_pkg, ccf_ram and ccf_cnt
`timescale 1ns / 1ps

//  word      handshake            fields
//  command   in_valid/in_ready    action object_type all_types credits_in new_count
//  result    out_valid/out_ready  status head_type credits_out count_out queue_empty
//  config    cfg_we               cfg_wdata (count limit shared by all types)
//
// count and set count go from S_CMD to S_FIN and a registered result; an accepted add goes through
// S_ADD1 and S_ADD2, a remove head through S_RH1 and S_RH2. cancel reads the list from the tail in
// S_WALK (one ram read a cycle), unlinks a match in S_CX, and goes to S_FIN when none is found.
// one command is in flight at a time; the next can be taken as soon as the registered result shows.
// a stalled result holds the sequencer in its final state.
// no clearing pass after reset: fresh slots are handed out by a fill count.

module class_counted_fifo_with_cancel_unit #(
	parameter int TYPE_COUNT  = ccf_pkg::TYPE_COUNT_DEF,
	parameter int QUEUE_DEPTH = ccf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ccf_pkg::ACT_W-1:0]   action,
	input  logic [ccf_pkg::TYPE_W-1:0]  object_type,
	input  logic                        all_types,
	input  logic [ccf_pkg::CRED_W-1:0]  credits_in,
	input  logic [ccf_pkg::CNT_W-1:0]   new_count,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [ccf_pkg::STAT_W-1:0]  status,
	output logic [ccf_pkg::TYPE_W-1:0]  head_type,
	output logic [ccf_pkg::CRED_W-1:0]  credits_out,
	output logic [ccf_pkg::SUM_W-1:0]   count_out,
	output logic                        queue_empty,
	input  logic                        cfg_we,
	input  logic [ccf_pkg::CNT_W-1:0]   cfg_wdata
);
	import ccf_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int SW = AW + 1;
	localparam int DW = TYPE_W + CRED_W;
	localparam logic [SW-1:0] NIL = SW'(QUEUE_DEPTH);
	localparam logic [TYPE_W:0] TYPE_LIM = (TYPE_W+1)'(TYPE_COUNT);

	state_t state_q, state_nx;

	logic [ACT_W-1:0]  act_q;
	logic [TYPE_W-1:0] typ_q;
	logic              all_q;
	logic [CRED_W-1:0] cred_q;
	logic [CNT_W-1:0]  nc_q;
	logic [CNT_W-1:0]  limit_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [SW-1:0] head_q, tail_q, free_q, fresh_q, slot_q, pv_q, nx_q;

	logic [STAT_W-1:0] res_status_q;
	logic [TYPE_W-1:0] res_htype_q;
	logic [CRED_W-1:0] res_cred_q;
	logic [SUM_W-1:0]  res_count_q;

	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [TYPE_W-1:0] head_type_q;
	logic [CRED_W-1:0] credits_out_q;
	logic [SUM_W-1:0]  count_out_q;
	logic              queue_empty_q;

	// ram ports
	logic [AW-1:0] rd_addr;
	logic          d_we, n_we, p_we;
	logic [AW-1:0] d_waddr, n_waddr, p_waddr;
	logic [DW-1:0] d_wdata, d_rdata;
	logic [SW-1:0] n_wdata, n_rdata, p_wdata, p_rdata;

	logic [TYPE_W-1:0] cnt_raddr;
	cnt_wr_t           cnt_wr;
	logic [CNT_W-1:0]  cnt_val;
	logic [SUM_W-1:0]  cnt_sum;

	logic          accept;
	logic          type_ok;
	logic          full;
	logic [SW-1:0] alloc;
	logic          add_refused;
	logic          walk_hit;
	logic          out_free;

	ccf_ram #(.WIDTH(DW), .DEPTH(QUEUE_DEPTH)) u_data_ram (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(rd_addr), .rdata(d_rdata)
	);

	ccf_ram #(.WIDTH(SW), .DEPTH(QUEUE_DEPTH)) u_next_ram (
		.clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
		.raddr(rd_addr), .rdata(n_rdata)
	);

	ccf_ram #(.WIDTH(SW), .DEPTH(QUEUE_DEPTH)) u_prev_ram (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(rd_addr), .rdata(p_rdata)
	);

	ccf_cnt #(.TYPE_COUNT(TYPE_COUNT)) u_cnt (
		.clk(clk), .arst_n(arst_n), .raddr(cnt_raddr), .wr(cnt_wr),
		.rd_val(cnt_val), .sum(cnt_sum)
	);

	assign in_ready    = (state_q == S_IDLE);
	assign accept      = in_valid && in_ready;
	assign type_ok     = {1'b0, typ_q} < TYPE_LIM;
	assign full        = (free_q == NIL) && (fresh_q == NIL);
	// released slots are reused first, then untouched ones in order
	assign alloc       = (free_q != NIL) ? free_q : fresh_q;
	assign add_refused = !type_ok || (cnt_val >= limit_q) || full;
	assign walk_hit    = (d_rdata[DW-1:CRED_W] == typ_q);
	assign out_free    = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_nx = S_CMD;
			end
			S_CMD: begin
				case (act_q)
					ACT_ADD:    state_nx = add_refused ? S_FIN : S_ADD1;
					ACT_REMOVE: state_nx = (head_q == NIL) ? S_FIN : S_RH1;
					ACT_CANCEL: state_nx = (tail_q == NIL || !type_ok) ? S_FIN : S_WALK;
					default:    state_nx = S_FIN;
				endcase
			end
			S_ADD1: state_nx = S_ADD2;
			S_ADD2: state_nx = S_FIN;
			S_RH1:  state_nx = S_RH2;
			S_RH2:  state_nx = S_FIN;
			S_WALK: begin
				if (walk_hit) state_nx = S_CX;
				else if (p_rdata == NIL) state_nx = S_FIN;
			end
			S_CX:  state_nx = S_FIN;
			S_FIN: begin
				if (out_free) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// ram and counter controls
	always_comb begin
		rd_addr   = slot_q[AW-1:0];
		d_we      = 1'b0;
		d_waddr   = slot_q[AW-1:0];
		d_wdata   = {typ_q, cred_q};
		n_we      = 1'b0;
		n_waddr   = slot_q[AW-1:0];
		n_wdata   = NIL;
		p_we      = 1'b0;
		p_waddr   = slot_q[AW-1:0];
		p_wdata   = NIL;
		cnt_raddr = typ_q;
		cnt_wr    = '0;
		case (state_q)
			S_IDLE: cnt_raddr = object_type;
			S_CMD: begin
				case (act_q)
					ACT_ADD:    rd_addr = free_q[AW-1:0];
					ACT_REMOVE: rd_addr = head_q[AW-1:0];
					default:    rd_addr = tail_q[AW-1:0];
				endcase
				if (act_q == ACT_SET && type_ok) begin
					cnt_wr = '{we: 1'b1, addr: typ_q, wdata: nc_q, old: cnt_val};
				end
			end
			S_ADD1: begin
				d_we   = 1'b1;
				n_we   = 1'b1;
				p_we   = 1'b1;
				p_wdata = tail_q;
				cnt_wr = '{we: 1'b1, addr: typ_q, wdata: cnt_q + 1'b1, old: cnt_q};
			end
			S_ADD2: begin
				n_we    = (tail_q != NIL);
				n_waddr = tail_q[AW-1:0];
				n_wdata = slot_q;
			end
			S_RH1: begin
				cnt_raddr = d_rdata[DW-1:CRED_W];
				p_we      = (n_rdata != NIL);
				p_waddr   = n_rdata[AW-1:0];
				n_we      = 1'b1;
				n_waddr   = head_q[AW-1:0];
				n_wdata   = free_q;
			end
			S_RH2: begin
				cnt_raddr = res_htype_q;
				if (cnt_val != '0) begin
					cnt_wr = '{we: 1'b1, addr: res_htype_q,
					           wdata: cnt_val - 1'b1, old: cnt_val};
				end
			end
			S_WALK: begin
				rd_addr = p_rdata[AW-1:0];
				if (walk_hit) begin
					p_we    = (n_rdata != NIL);
					p_waddr = n_rdata[AW-1:0];
					p_wdata = p_rdata;
					n_we    = 1'b1;
					n_wdata = free_q;
					if (cnt_q != '0) begin
						cnt_wr = '{we: 1'b1, addr: typ_q, wdata: cnt_q - 1'b1, old: cnt_q};
					end
				end
			end
			S_CX: begin
				n_we    = (pv_q != NIL);
				n_waddr = pv_q[AW-1:0];
				n_wdata = nx_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			limit_q     <= LIMIT_RESET;
			head_q      <= NIL;
			tail_q      <= NIL;
			free_q      <= NIL;
			fresh_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) limit_q <= cfg_wdata;
			out_valid_q <= (state_q == S_FIN && out_free) || (out_valid_q && !out_ready);
			case (state_q)
				S_ADD1: begin
					if (free_q != NIL) free_q <= n_rdata;
					else fresh_q <= fresh_q + 1'b1;
				end
				S_ADD2: begin
					if (tail_q == NIL) head_q <= slot_q;
					tail_q <= slot_q;
				end
				S_RH1: begin
					head_q <= n_rdata;
					if (n_rdata == NIL) tail_q <= NIL;
					free_q <= head_q;
				end
				S_WALK: begin
					if (walk_hit) begin
						if (n_rdata == NIL) tail_q <= p_rdata;
						free_q <= slot_q;
					end
				end
				S_CX: begin
					if (pv_q == NIL) head_q <= nx_q;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				act_q        <= action;
				typ_q        <= object_type;
				all_q        <= all_types;
				cred_q       <= credits_in;
				nc_q         <= new_count;
				res_status_q <= STAT_OK;
				res_htype_q  <= '0;
				res_cred_q   <= '0;
				res_count_q  <= '0;
			end
			S_CMD: begin
				cnt_q <= cnt_val;
				case (act_q)
					ACT_ADD: begin
						if (add_refused) res_status_q <= STAT_REFUSED;
						slot_q <= alloc;
					end
					ACT_REMOVE: begin
						if (head_q == NIL) res_status_q <= STAT_MISS;
						slot_q <= head_q;
					end
					ACT_CANCEL: begin
						res_status_q <= STAT_MISS;
						slot_q <= tail_q;
					end
					ACT_COUNT: begin
						res_count_q <= (all_q || !type_ok) ? cnt_sum : SUM_W'(cnt_val);
					end
					default: ;
				endcase
			end
			S_RH1: res_htype_q <= d_rdata[DW-1:CRED_W];
			S_WALK: begin
				if (walk_hit) begin
					res_status_q <= STAT_OK;
					res_cred_q   <= d_rdata[CRED_W-1:0];
					pv_q         <= p_rdata;
					nx_q         <= n_rdata;
				end else begin
					slot_q <= p_rdata;
				end
			end
			S_FIN: begin
				if (out_free) begin
					status_q      <= res_status_q;
					head_type_q   <= res_htype_q;
					credits_out_q <= res_cred_q;
					count_out_q   <= res_count_q;
					queue_empty_q <= (head_q == NIL);
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign head_type   = head_type_q;
	assign credits_out = credits_out_q;
	assign count_out   = count_out_q;
	assign queue_empty = queue_empty_q;

	a_ends_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((head_q == NIL) == (tail_q == NIL)))
		else $error("head and tail disagree on empty list");

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= NIL)
		else $error("fill count past queue depth");

	a_accept_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_CMD))
		else $error("accepted word not dispatched");

	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free) |=> (out_valid_q && state_q == S_IDLE))
		else $error("result not registered on finish");

endmodule
